/* sv/prp_pkg.sv */
`default_nettype none
package prp_pkg;

  localparam int DIV_W = 40;

  typedef struct packed {
    logic [23:0] release_altitude_setting;
    logic [15:0] minimum_sink_rate;
    logic [15:0] canopy_open_time;
    logic [15:0] deployment_delay;
  } cfg_t;

  // travels alongside the divider stages
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic [23:0]        flo;
    logic [23:0]        ralt;
    logic [47:0]        g_term;
    logic signed [32:0] w_al;
    logic [2:0]         neg;
  } side_t;

  // register indexes, byte address is index * 4
  localparam logic [1:0] REG_ALT = 2'd0;
  localparam logic [1:0] REG_MIN_SINK = 2'd1;
  localparam logic [1:0] REG_COT = 2'd2;
  localparam logic [1:0] REG_DELAY = 2'd3;

  localparam logic [23:0] RST_ALT = 24'd7680;
  localparam logic [15:0] RST_MIN_SINK = 16'd512;
  localparam logic [15:0] RST_COT = 16'd768;
  localparam logic [15:0] RST_DELAY = 16'd256;

endpackage
`default_nettype wire

/* sv/prp_if.sv */
`default_nettype none
interface prp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ground_vel_x;
  logic signed [15:0] ground_vel_y;
  logic signed [15:0] wind_x;
  logic signed [15:0] wind_y;
  logic               wind_ok;
  logic signed [15:0] approach_x;
  logic signed [15:0] approach_y;
  logic signed [23:0] height_above_ground;
  logic signed [15:0] descent_rate;
  modport source(output valid, ground_vel_x, ground_vel_y, wind_x, wind_y, wind_ok,
                 approach_x, approach_y, height_above_ground, descent_rate,
                 input ready);
  modport sink(input valid, ground_vel_x, ground_vel_y, wind_x, wind_y, wind_ok,
               approach_x, approach_y, height_above_ground, descent_rate,
               output ready);
endinterface

interface prp_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        safe_floor;
  logic [23:0]        release_altitude;
  logic signed [31:0] aim_shift_x;
  logic signed [31:0] aim_shift_y;
  logic signed [31:0] release_lead;
  modport source(output valid, safe_floor, release_altitude, aim_shift_x, aim_shift_y,
                 release_lead, input ready);
  modport sink(input valid, safe_floor, release_altitude, aim_shift_x, aim_shift_y,
               release_lead, output ready);
endinterface
`default_nettype wire

/* sv/prp_front.sv */
`default_nettype none
module prp_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire prp_pkg::cfg_t        cfg,
  prp_in_if.sink                    req,
  output logic                      out_valid,
  output logic [prp_pkg::DIV_W-1:0] num0,
  output logic [prp_pkg::DIV_W-1:0] num1,
  output logic [prp_pkg::DIV_W-1:0] num2,
  output logic [15:0]               den,
  output prp_pkg::side_t            side
);

  logic [3:1] v;

  // stage 1
  logic [15:0]        s_c;
  logic [15:0]        s1;
  logic [31:0]        pf1;
  logic signed [31:0] gxa1, gya1, wxa1, wya1;
  logic signed [23:0] hag1;
  logic signed [15:0] wx1, wy1, ax1, ay1;
  logic               wok1;

  always_comb begin
    if ($signed({1'b0, req.descent_rate}) > $signed({2'b0, cfg.minimum_sink_rate}) &&
        !req.descent_rate[15]) begin
      s_c = req.descent_rate;
    end else begin
      s_c = cfg.minimum_sink_rate;
    end
    if (s_c == 16'd0) s_c = 16'd1;
  end

  // stage 2
  logic [32:0]        pfr;
  logic [24:0]        fl_c;
  logic [23:0]        flo_c, ralt_c;
  logic signed [32:0] gal_c, wal_c;
  logic [15:0]        s2;
  logic [23:0]        flo2, ralt2;
  logic [31:0]        gal2;
  logic signed [32:0] wal2;
  logic signed [23:0] hag2;
  logic signed [15:0] wx2, wy2, ax2, ay2;

  always_comb begin
    pfr = {1'b0, pf1} + 33'd128;
    fl_c = pfr[32:8];
    flo_c = fl_c[24] ? 24'hFFFFFF : fl_c[23:0];
    ralt_c = (flo_c > cfg.release_altitude_setting) ? flo_c : cfg.release_altitude_setting;
    gal_c = 33'(gxa1) + 33'(gya1);
    wal_c = wok1 ? (33'(wxa1) + 33'(wya1)) : 33'sd0;
  end

  // stage 3
  logic signed [24:0] hag25;
  logic [23:0]        expd_c;
  logic signed [40:0] nx3, ny3;
  logic [47:0]        gterm3;
  logic [15:0]        s3;
  logic [23:0]        flo3, ralt3;
  logic signed [32:0] wal3;
  logic signed [23:0] hag3;
  logic signed [15:0] ax3, ay3;

  always_comb begin
    hag25 = 25'(hag2);
    if (hag25 < $signed({1'b0, flo2})) expd_c = flo2;
    else if (hag25 > $signed({1'b0, ralt2})) expd_c = ralt2;
    else expd_c = hag2[23:0];
  end

  // stage 4: magnitudes plus half divisor for round-to-nearest
  logic [40:0] mx_c, my_c;
  logic [23:0] mh_c;

  always_comb begin
    mx_c = nx3[40] ? 41'(-nx3) : 41'(nx3);
    my_c = ny3[40] ? 41'(-ny3) : 41'(ny3);
    mh_c = hag3[23] ? 24'(-hag3) : 24'(hag3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[2:1], req.valid};
      out_valid <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s_c;
      pf1 <= 32'(s_c) * 32'(cfg.canopy_open_time);
      gxa1 <= req.ground_vel_x * req.approach_x;
      gya1 <= req.ground_vel_y * req.approach_y;
      wxa1 <= req.wind_x * req.approach_x;
      wya1 <= req.wind_y * req.approach_y;
      hag1 <= req.height_above_ground;
      wx1 <= req.wind_x;
      wy1 <= req.wind_y;
      ax1 <= req.approach_x;
      ay1 <= req.approach_y;
      wok1 <= req.wind_ok;

      s2 <= s1;
      flo2 <= flo_c;
      ralt2 <= ralt_c;
      gal2 <= gal_c[32] ? 32'd0 : gal_c[31:0];
      wal2 <= wal_c;
      hag2 <= hag1;
      wx2 <= wx1;
      wy2 <= wy1;
      ax2 <= ax1;
      ay2 <= ay1;

      nx3 <= wx2 * $signed({1'b0, expd_c});
      ny3 <= wy2 * $signed({1'b0, expd_c});
      gterm3 <= 48'(gal2) * 48'(cfg.deployment_delay);
      s3 <= s2;
      flo3 <= flo2;
      ralt3 <= ralt2;
      wal3 <= wal2;
      hag3 <= hag2;
      ax3 <= ax2;
      ay3 <= ay2;

      num0 <= mx_c[39:0] + 40'(s3[15:1]);
      num1 <= my_c[39:0] + 40'(s3[15:1]);
      num2 <= 40'({mh_c, 8'd0}) + 40'(s3[15:1]);
      den <= s3;
      side.ax <= ax3;
      side.ay <= ay3;
      side.flo <= flo3;
      side.ralt <= ralt3;
      side.g_term <= gterm3;
      side.w_al <= wal3;
      side.neg <= {hag3[23], ny3[40], nx3[40]};
    end
  end

endmodule
`default_nettype wire

/* sv/prp_divider.sv */
`default_nettype none
module prp_divider (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [prp_pkg::DIV_W-1:0] num0,
  input  wire logic [prp_pkg::DIV_W-1:0] num1,
  input  wire logic [prp_pkg::DIV_W-1:0] num2,
  input  wire logic [15:0]          den,
  input  wire prp_pkg::side_t       side_in,
  output logic                      out_valid,
  output logic [prp_pkg::DIV_W-1:0] q0,
  output logic [prp_pkg::DIV_W-1:0] q1,
  output logic [prp_pkg::DIV_W-1:0] q2,
  output prp_pkg::side_t            side_out
);

  localparam int NS = prp_pkg::DIV_W;

  // restoring division, one quotient bit per stage; quotient shifts in at the bottom
  typedef struct packed {
    logic [15:0]   r;
    logic [NS-1:0] n;
  } dstep_t;

  function automatic dstep_t div_step(input logic [15:0] r, input logic [NS-1:0] n,
                                      input logic [15:0] d);
    logic [16:0] t;
    logic [16:0] diff;
    logic        ge;
    dstep_t      o;
    t = {r, n[NS-1]};
    diff = t - {1'b0, d};
    ge = (t >= {1'b0, d});
    o.r = ge ? diff[15:0] : t[15:0];
    o.n = {n[NS-2:0], ge};
    return o;
  endfunction

  logic [NS-1:0]  vld;
  dstep_t         st [NS][3];
  logic [15:0]    dd [NS];
  prp_pkg::side_t sd [NS];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0][0] <= div_step(16'd0, num0, den);
      st[0][1] <= div_step(16'd0, num1, den);
      st[0][2] <= div_step(16'd0, num2, den);
      dd[0] <= den;
      sd[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        for (int j = 0; j < 3; j++) begin
          st[k][j] <= div_step(st[k-1][j].r, st[k-1][j].n, dd[k-1]);
        end
        dd[k] <= dd[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign q0 = st[NS-1][0].n;
  assign q1 = st[NS-1][1].n;
  assign q2 = st[NS-1][2].n;
  assign side_out = sd[NS-1];

endmodule
`default_nettype wire

/* sv/prp_back.sv */
`default_nettype none
module prp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  output logic                      en,
  input  wire logic                 in_valid,
  input  wire logic [prp_pkg::DIV_W-1:0] q0,
  input  wire logic [prp_pkg::DIV_W-1:0] q1,
  input  wire logic [prp_pkg::DIV_W-1:0] q2,
  input  wire prp_pkg::side_t       side,
  prp_out_if.source                 res
);

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    if (x > 68'sd2147483647) return 32'sh7FFFFFFF;
    else if (x < -68'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  logic [5:1] v;
  logic       ovalid;

  assign en = !ovalid || res.ready;

  // B1
  logic signed [40:0] dx1, dy1;
  logic signed [32:0] td1;
  logic signed [15:0] ax1, ay1;
  logic [23:0]        flo1, ralt1;
  logic [47:0]        gt1;
  logic signed [32:0] wal1;
  // B2
  logic signed [36:0] pxl2, pxh2, pyl2, pyh2;
  logic signed [50:0] wl2;
  logic signed [48:0] wh2;
  logic signed [40:0] dx2, dy2;
  logic signed [15:0] ax2, ay2;
  logic [23:0]        flo2, ralt2;
  logic [47:0]        gt2;
  // B3
  logic signed [57:0] dot_c;
  logic signed [67:0] ls_c;
  logic signed [43:0] proj3;
  logic signed [67:0] ls3;
  logic signed [40:0] dx3, dy3;
  logic signed [15:0] ax3, ay3;
  logic [23:0]        flo3, ralt3;
  // B4
  logic signed [38:0] qxl4, qyl4;
  logic signed [37:0] qxh4, qyh4;
  logic signed [45:0] lr4;
  logic signed [40:0] dx4, dy4;
  logic [23:0]        flo4, ralt4;
  // B5
  logic signed [60:0] sxp_c, syp_c;
  logic signed [46:0] rx5, ry5;
  logic signed [45:0] lr5;
  logic signed [40:0] dx5, dy5;
  logic [23:0]        flo5, ralt5;

  always_comb begin
    dot_c = 58'(pxl2) + (58'(pxh2) <<< 20) + 58'(pyl2) + (58'(pyh2) <<< 20) + 58'sd8192;
    ls_c = $signed({20'd0, gt2}) + 68'(wl2) + (68'(wh2) <<< 17);
    sxp_c = 61'(qxl4) + (61'(qxh4) <<< 22) + 61'sd8192;
    syp_c = 61'(qyl4) + (61'(qyh4) <<< 22) + 61'sd8192;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      ovalid <= 1'b0;
    end else if (en) begin
      v <= {v[4:1], in_valid};
      ovalid <= v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= side.neg[0] ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
      dy1 <= side.neg[1] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      td1 <= side.neg[2] ? -$signed({1'b0, q2[31:0]}) : $signed({1'b0, q2[31:0]});
      ax1 <= side.ax;
      ay1 <= side.ay;
      flo1 <= side.flo;
      ralt1 <= side.ralt;
      gt1 <= side.g_term;
      wal1 <= side.w_al;

      pxl2 <= $signed({1'b0, dx1[19:0]}) * ax1;
      pxh2 <= $signed(dx1[40:20]) * ax1;
      pyl2 <= $signed({1'b0, dy1[19:0]}) * ay1;
      pyh2 <= $signed(dy1[40:20]) * ay1;
      wl2 <= $signed({1'b0, td1[16:0]}) * wal1;
      wh2 <= $signed(td1[32:17]) * wal1;
      dx2 <= dx1;
      dy2 <= dy1;
      ax2 <= ax1;
      ay2 <= ay1;
      flo2 <= flo1;
      ralt2 <= ralt1;
      gt2 <= gt1;

      proj3 <= 44'(dot_c >>> 14);
      ls3 <= ls_c;
      dx3 <= dx2;
      dy3 <= dy2;
      ax3 <= ax2;
      ay3 <= ay2;
      flo3 <= flo2;
      ralt3 <= ralt2;

      qxl4 <= $signed({1'b0, proj3[21:0]}) * ax3;
      qxh4 <= $signed(proj3[43:22]) * ax3;
      qyl4 <= $signed({1'b0, proj3[21:0]}) * ay3;
      qyh4 <= $signed(proj3[43:22]) * ay3;
      lr4 <= 46'((ls3 + (68'sd1 <<< 21)) >>> 22);
      dx4 <= dx3;
      dy4 <= dy3;
      flo4 <= flo3;
      ralt4 <= ralt3;

      rx5 <= 47'(sxp_c >>> 14);
      ry5 <= 47'(syp_c >>> 14);
      lr5 <= lr4;
      dx5 <= dx4;
      dy5 <= dy4;
      flo5 <= flo4;
      ralt5 <= ralt4;

      res.safe_floor <= flo5;
      res.release_altitude <= ralt5;
      res.aim_shift_x <= sat32(68'(dx5) - 68'(rx5));
      res.aim_shift_y <= sat32(68'(dy5) - 68'(ry5));
      res.release_lead <= sat32(68'(lr5));
    end
  end

  assign res.valid = ovalid;

endmodule
`default_nettype wire

/* sv/parachute_release_planner_top.sv */
`default_nettype none
// channel  dir  handshake     payload
// req      in   valid/ready   velocities, wind, approach, height, descent rate
// res      out  valid/ready   release floor/altitude, aim shift x/y, release lead
// cfg      in   APB write/rd  four registers at byte offsets 0, 4, 8, 12
//
// One transaction per cycle sustained unless res stalls; 4 front stages,
// 40 divider stages (one quotient bit each, three dividers sharing the divisor),
// 6 back stages ending in the output register.
// Synchronous active-high reset clears valid bits and loads register defaults.
// A stall on res freezes the whole pipeline; bubbles are not squeezed out.
module parachute_release_planner_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  prp_in_if.sink           req,
  prp_out_if.source        res
);

  prp_pkg::cfg_t cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.release_altitude_setting <= prp_pkg::RST_ALT;
      cfg.minimum_sink_rate <= prp_pkg::RST_MIN_SINK;
      cfg.canopy_open_time <= prp_pkg::RST_COT;
      cfg.deployment_delay <= prp_pkg::RST_DELAY;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        prp_pkg::REG_ALT:      cfg.release_altitude_setting <= pwdata[23:0];
        prp_pkg::REG_MIN_SINK: cfg.minimum_sink_rate <= pwdata[15:0];
        prp_pkg::REG_COT:      cfg.canopy_open_time <= pwdata[15:0];
        prp_pkg::REG_DELAY:    cfg.deployment_delay <= pwdata[15:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      prp_pkg::REG_ALT:      prdata = {8'd0, cfg.release_altitude_setting};
      prp_pkg::REG_MIN_SINK: prdata = {16'd0, cfg.minimum_sink_rate};
      prp_pkg::REG_COT:      prdata = {16'd0, cfg.canopy_open_time};
      prp_pkg::REG_DELAY:    prdata = {16'd0, cfg.deployment_delay};
      default:               prdata = 32'd0;
    endcase
  end

  logic                      en;
  logic                      fv, dv;
  logic [prp_pkg::DIV_W-1:0] n0, n1, n2, q0, q1, q2;
  logic [15:0]               den;
  prp_pkg::side_t            fside, dside;

  assign req.ready = en;

  prp_front u_front (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg), .req(req),
    .out_valid(fv), .num0(n0), .num1(n1), .num2(n2), .den(den), .side(fside)
  );

  prp_divider u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(fv),
    .num0(n0), .num1(n1), .num2(n2), .den(den), .side_in(fside),
    .out_valid(dv), .q0(q0), .q1(q1), .q2(q2), .side_out(dside)
  );

  prp_back u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(dv),
    .q0(q0), .q1(q1), .q2(q2), .side(dside), .res(res)
  );

  a_alt_ge_floor: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.release_altitude >= res.safe_floor)
    else $error("release altitude below floor");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !req.ready)
    else $error("input accepted during output stall");

  a_no_valid_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
